FILE: rtl/pattern_mask_filter_core_defines.svh
// Assertion macros used by the checker file.
`ifndef PATTERN_MASK_FILTER_CORE_DEFINES_SVH
`define PATTERN_MASK_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pmf_pkg.sv
`timescale 1ns / 1ps

package pmf_pkg;

    // Largest supported pattern, default for the top-level parameter
    localparam int MAX_PATTERN_DEF = 8;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_LEN_W = 4;
    localparam int CFG_IDX_W = 1;

    // Group size field: holds 0..8 bytes for any legal pattern length
    localparam int GRP_CNT_W = 4;

    // Mask character
    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    // Control for one group of result bytes handed to the output buffer
    typedef struct packed {
        logic                 vld;
        logic                 last;
        logic [GRP_CNT_W-1:0] cnt;
    } grp_ctl_t;

endpackage

FILE: rtl/pmf_cfg.sv
`timescale 1ns / 1ps

module pmf_cfg #(
    parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF,
    localparam int FILL_W = $clog2(MAX_PATTERN + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [pmf_pkg::CFG_DATA_W-1:0] pat_bytes,
    output logic [FILL_W-1:0]             pat_len
);

    logic [pmf_pkg::CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [pmf_pkg::PAT_LEN_W-1:0]  pattern_length_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= pmf_pkg::PAT_LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pmf_pkg::CFG_PATTERN_BYTES:
                begin
                    pattern_bytes_reg <= cfg_data;
                end
                pmf_pkg::CFG_PATTERN_LENGTH:
                begin
                    pattern_length_reg <= cfg_data[pmf_pkg::PAT_LEN_W-1:0];
                end
                default:
                begin
                    pattern_bytes_reg <= pattern_bytes_reg;
                end
            endcase
        end
    end

    // Effective length: zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (pattern_length_reg == '0)
            pat_len = FILL_W'(1);
        else if (pattern_length_reg > pmf_pkg::PAT_LEN_W'(MAX_PATTERN))
            pat_len = FILL_W'(MAX_PATTERN);
        else
            pat_len = FILL_W'(pattern_length_reg);
    end

    assign pat_bytes = pattern_bytes_reg;

endmodule

FILE: rtl/pmf_window.sv
`timescale 1ns / 1ps

module pmf_window #(
    parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF,
    localparam int FILL_W = $clog2(MAX_PATTERN + 1),
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    localparam int SUM_W  = FILL_W + 1
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [pmf_pkg::BYTE_W-1:0]                   data_byte,
    input  logic                                         in_last,
    input  logic [pmf_pkg::CFG_DATA_W-1:0]               pat_bytes,
    input  logic [FILL_W-1:0]                            pat_len,
    input  logic                                         room,
    output pmf_pkg::grp_ctl_t                            grp_ctl,
    output logic [MAX_PATTERN-1:0][pmf_pkg::BYTE_W-1:0]  grp_bytes
);

    // Input register
    logic                       ir_vld_reg, ir_vld_next;
    logic [pmf_pkg::BYTE_W-1:0] ir_byte_reg;
    logic                       ir_last_reg;

    // Window, oldest byte at index 0
    logic [MAX_PATTERN-1:0][pmf_pkg::BYTE_W-1:0] win_reg, win_next;
    logic [FILL_W-1:0]                           fill_reg, fill_next;

    logic [MAX_PATTERN-1:0][pmf_pkg::BYTE_W-1:0] w, r;
    logic [MAX_PATTERN-1:0][SUM_W-1:0]           cmp_idx, keep_idx;
    logic [FILL_W-1:0]                           wfill, surplus, pop_cnt, emit_cnt;
    logic                                        accept, step_go, full, match;

    // Handshake: the input register drains whenever the output buffer has room
    assign step_go     = ir_vld_reg & room;
    assign in_stall    = ir_vld_reg & ~room;
    assign accept      = in_valid & ~in_stall;
    assign ir_vld_next = accept | (ir_vld_reg & ~step_go);

    // One step of the window
    always_comb
    begin
        wfill = fill_reg + FILL_W'(1);
        full  = (wfill >= pat_len);
        surplus = (wfill > pat_len) ? (wfill - pat_len) : '0;

        // Window with the new byte appended
        for (int k = 0; k < MAX_PATTERN; k++)
            w[k] = (fill_reg == FILL_W'(k)) ? ir_byte_reg : win_reg[k];

        // Candidate match region, past the surplus bytes
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            cmp_idx[k] = SUM_W'(surplus) + SUM_W'(k);
            r[k] = (cmp_idx[k] < SUM_W'(MAX_PATTERN)) ? w[cmp_idx[k][IDX_W-1:0]] : '0;
        end

        match = full;
        for (int k = 0; k < MAX_PATTERN; k++)
            if ((FILL_W'(k) < pat_len) && (r[k] != pat_bytes[8*k +: 8]))
                match = 1'b0;

        // Unmatched: emit surplus plus oldest when full; flush all on last
        if (ir_last_reg)
            pop_cnt = wfill;
        else if (full)
            pop_cnt = surplus + FILL_W'(1);
        else
            pop_cnt = surplus;

        // Matched: surplus bytes then stars, window empties
        emit_cnt = match ? wfill : pop_cnt;

        for (int j = 0; j < MAX_PATTERN; j++)
            grp_bytes[j] = (match && (FILL_W'(j) >= surplus)) ? pmf_pkg::STAR_BYTE : w[j];

        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            keep_idx[k] = SUM_W'(emit_cnt) + SUM_W'(k);
            win_next[k] = (keep_idx[k] < SUM_W'(MAX_PATTERN))
                        ? w[keep_idx[k][IDX_W-1:0]] : '0;
        end
        fill_next = wfill - emit_cnt;

        grp_ctl.vld  = step_go && (emit_cnt != '0);
        grp_ctl.last = ir_last_reg;
        grp_ctl.cnt  = pmf_pkg::GRP_CNT_W'(emit_cnt);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_vld_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            ir_vld_reg <= ir_vld_next;
            if (step_go)
                fill_reg <= fill_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_byte_reg <= data_byte;
            ir_last_reg <= in_last;
        end
        if (step_go)
            win_reg <= win_next;
    end

endmodule

FILE: rtl/pmf_obuf.sv
`timescale 1ns / 1ps

module pmf_obuf #(
    parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF,
    localparam int DEPTH = 2 * MAX_PATTERN,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  pmf_pkg::grp_ctl_t                           grp_ctl,
    input  logic [MAX_PATTERN-1:0][pmf_pkg::BYTE_W-1:0] grp_bytes,
    output logic                                        room,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic [pmf_pkg::BYTE_W-1:0]                  out_byte,
    output logic                                        out_last
);

    // Byte queue, head at index 0
    logic [DEPTH-1:0][pmf_pkg::BYTE_W-1:0] q_reg, q_next, q_sh;
    logic [DEPTH-1:0]                      l_reg, l_next, l_sh;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next, base, grp_n;
    logic [DEPTH-1:0][CNT_W-1:0]           off;
    logic [DEPTH-1:0]                      hit;
    logic                                  pop;

    assign out_valid = (cnt_reg != '0);
    assign out_byte  = q_reg[0];
    assign out_last  = l_reg[0];
    assign pop       = out_valid & ~out_stall;
    assign room      = (cnt_reg <= CNT_W'(MAX_PATTERN));

    // Pop the head, then append the new group after the remaining entries
    always_comb
    begin
        q_sh  = pop ? (q_reg >> pmf_pkg::BYTE_W) : q_reg;
        l_sh  = pop ? (l_reg >> 1) : l_reg;
        base  = cnt_reg - CNT_W'(pop);
        grp_n = grp_ctl.vld ? CNT_W'(grp_ctl.cnt) : '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            off[i] = CNT_W'(i) - base;
            hit[i] = (CNT_W'(i) >= base) && (off[i] < grp_n);
            q_next[i] = hit[i] ? grp_bytes[off[i][IDX_W-1:0]] : q_sh[i];
            l_next[i] = hit[i] ? (grp_ctl.last && (off[i] == grp_n - CNT_W'(1))) : l_sh[i];
        end
        cnt_next = base + grp_n;
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Queue contents
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        l_reg <= l_next;
    end

endmodule

FILE: rtl/pattern_mask_filter_core.sv
`timescale 1ns / 1ps

// Channel | Valid     | Stall     | Payload
// --------+-----------+-----------+--------------------------------------
// input   | in_valid  | in_stall  | data_byte[7:0], in_last
// output  | out_valid | out_stall | out_byte[7:0], out_last
// config  | cfg_write | (none)    | cfg_index, cfg_data[63:0]
//
// One input transaction per cycle while in_stall is low; a step emits 0 to MAX_PATTERN bytes.
// Results leave one per cycle while out_stall is low, after the input register and the queue.
// A queue of 2*MAX_PATTERN bytes decouples the sides; in_stall rises only
// while the queue holds more than MAX_PATTERN bytes.
// rst_n clears the window fill, input register valid flag and queue count at once.

module pattern_mask_filter_core #(
    parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pmf_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pmf_pkg::BYTE_W-1:0]     out_byte,
    output logic                           out_last
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [pmf_pkg::CFG_DATA_W-1:0]              pat_bytes;
    logic [FILL_W-1:0]                           pat_len;
    logic                                        room;
    pmf_pkg::grp_ctl_t                           grp_ctl;
    logic [MAX_PATTERN-1:0][pmf_pkg::BYTE_W-1:0] grp_bytes;

    // Pattern registers
    pmf_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat_bytes (pat_bytes),
        .pat_len   (pat_len)
    );

    // Input register and match window
    pmf_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .in_last   (in_last),
        .pat_bytes (pat_bytes),
        .pat_len   (pat_len),
        .room      (room),
        .grp_ctl   (grp_ctl),
        .grp_bytes (grp_bytes)
    );

    // Output queue
    pmf_obuf #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_ctl   (grp_ctl),
        .grp_bytes (grp_bytes),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

FILE: rtl/pmf_checker.sv
`timescale 1ns / 1ps

`include "pattern_mask_filter_core_defines.svh"

module pmf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [pmf_pkg::BYTE_W-1:0] out_byte,
    input logic                       out_last
);

    // A stalled result holds
    `PMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(out_last), "stalled result changed")

    // Input is held off only while the output queue is backed up
    `PMF_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid, "input stalled with queue empty")

    // A result after an empty queue comes from an input that passed the input register and the queue
    `PMF_ASSERT_NOW(a_rise_has_source, $rose(out_valid),
        $past(in_valid && !in_stall, 2), "result without input transaction")

endmodule

bind pattern_mask_filter_core pmf_checker u_pmf_checker (.*);
